// File: hw/rtl/mbrtu_pkg.sv
// ----------------------------------------------------------------------------
// mbrtu_pkg
// Shared types and constants for the Modbus RTU frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package mbrtu_pkg;

  typedef logic [7:0]  byte_t;
  typedef logic [15:0] crc_t;

  localparam int unsigned NUM_SLOTS = 8;
  localparam int unsigned SLOT_W    = $clog2(NUM_SLOTS);

  typedef logic [NUM_SLOTS-1:0] slot_mask_t;
  typedef logic [SLOT_W-1:0]    slot_idx_t;

  localparam crc_t CRC_INIT = 16'hFFFF;
  localparam crc_t CRC_POLY = 16'hA001;
  localparam crc_t CRC_LSB  = 16'h0001;

  // Byte positions within the work of one input word, in sending order.
  localparam slot_idx_t SLOT_SID     = 3'd0;
  localparam slot_idx_t SLOT_FC      = 3'd1;
  localparam slot_idx_t SLOT_ADDR_HI = 3'd2;
  localparam slot_idx_t SLOT_ADDR_LO = 3'd3;
  localparam slot_idx_t SLOT_VAL_HI  = 3'd4;
  localparam slot_idx_t SLOT_VAL_LO  = 3'd5;
  localparam slot_idx_t SLOT_CRC_LO  = 3'd6;
  localparam slot_idx_t SLOT_CRC_HI  = 3'd7;

endpackage : mbrtu_pkg

`default_nettype wire

// File: hw/rtl/mbrtu_crc_byte.sv
// ----------------------------------------------------------------------------
// mbrtu_crc_byte
// Folds one byte into a CRC-16/Modbus value (reflected, LSB first).
// ----------------------------------------------------------------------------
`default_nettype none

module mbrtu_crc_byte (
  input  wire mbrtu_pkg::crc_t  crc_in,
  input  wire mbrtu_pkg::byte_t data,
  output mbrtu_pkg::crc_t       crc_out
);
  import mbrtu_pkg::*;

  always_comb begin
    crc_t c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if ((c & CRC_LSB) != '0) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule : mbrtu_crc_byte

`default_nettype wire

// File: hw/rtl/modbus_rtu_frame_builder.sv
// ----------------------------------------------------------------------------
// modbus_rtu_frame_builder
// Serializes Modbus RTU style frames with a trailing CRC-16/Modbus.
// ----------------------------------------------------------------------------
// Each accepted input word is latched into an item register together with a
// mask of the bytes it produces (header on the first word of a frame, two
// value bytes when has_value is set, two CRC bytes when end_of_frame is set).
// One byte per cycle, while the output register is empty or being accepted,
// moves from the item register into the output register, and the CRC is
// folded in as each header or value byte is loaded, so the CRC bytes are
// ready when their turn comes. The next word is taken in the same cycle the
// current word's last byte is loaded, so words flow back to back while the
// output accepts a byte every cycle. A word that emits nothing is absorbed
// without output. out_final_byte marks the CRC high byte that closes a frame.
// ----------------------------------------------------------------------------
`default_nettype none

module modbus_rtu_frame_builder (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output      logic             in_ready,
  input  wire mbrtu_pkg::byte_t in_slave_id,
  input  wire mbrtu_pkg::byte_t in_function_code,
  input  wire logic [15:0]      in_start_address,
  input  wire logic [15:0]      in_reg_value,
  input  wire logic             in_has_value,
  input  wire logic             in_end_of_frame,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output mbrtu_pkg::byte_t      out_frame_byte,
  output      logic             out_final_byte
);
  import mbrtu_pkg::*;

  // Item register.
  slot_mask_t  mask_r, mask_nxt;
  byte_t       sid_r, fc_r;
  logic [15:0] addr_r, val_r;

  // Frame state.
  crc_t        crc_r, crc_nxt;
  logic        inside_r, inside_nxt;

  // Output register.
  logic        out_valid_r, out_valid_nxt;
  byte_t       out_byte_r;
  logic        out_final_r;

  slot_idx_t   slot;
  slot_mask_t  slot_bit;
  slot_mask_t  mask_rem;
  byte_t       byte_sel;
  crc_t        crc_upd;
  logic        load;
  logic        accept;
  slot_mask_t  new_mask;

  // Lowest pending byte position goes out first.
  always_comb begin
    slot = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (mask_r[i]) begin
        slot = slot_idx_t'(i);
      end
    end
  end

  assign slot_bit = slot_mask_t'(1) << slot;

  always_comb begin
    unique case (slot)
      SLOT_SID:     byte_sel = sid_r;
      SLOT_FC:      byte_sel = fc_r;
      SLOT_ADDR_HI: byte_sel = addr_r[15:8];
      SLOT_ADDR_LO: byte_sel = addr_r[7:0];
      SLOT_VAL_HI:  byte_sel = val_r[15:8];
      SLOT_VAL_LO:  byte_sel = val_r[7:0];
      SLOT_CRC_LO:  byte_sel = crc_r[7:0];
      SLOT_CRC_HI:  byte_sel = crc_r[15:8];
      default:      byte_sel = '0;
    endcase
  end

  mbrtu_crc_byte u_crc (
    .crc_in  (crc_r),
    .data    (byte_sel),
    .crc_out (crc_upd)
  );

  assign load     = (mask_r != '0) && (!out_valid_r || out_ready);
  assign mask_rem = load ? (mask_r & ~slot_bit) : mask_r;
  assign in_ready = (mask_rem == '0);
  assign accept   = in_valid && in_ready;

  assign new_mask = {in_end_of_frame, in_end_of_frame, in_has_value, in_has_value,
                     {4{!inside_r}}};

  always_comb begin
    mask_nxt      = accept ? new_mask : mask_rem;
    inside_nxt    = accept ? !in_end_of_frame : inside_r;
    crc_nxt       = crc_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (slot == SLOT_CRC_HI) begin
        crc_nxt = CRC_INIT;
      end else if (slot != SLOT_CRC_LO) begin
        crc_nxt = crc_upd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      inside_r    <= 1'b0;
      crc_r       <= CRC_INIT;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      inside_r    <= inside_nxt;
      crc_r       <= crc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      sid_r  <= in_slave_id;
      fc_r   <= in_function_code;
      addr_r <= in_start_address;
      val_r  <= in_reg_value;
    end
    if (load) begin
      out_byte_r  <= byte_sel;
      out_final_r <= (slot == SLOT_CRC_HI);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_byte = out_byte_r;
  assign out_final_byte = out_final_r;

endmodule : modbus_rtu_frame_builder

`default_nettype wire

// File: hw/rtl/mbrtu_checker.sv
// ----------------------------------------------------------------------------
// mbrtu_checker
// Port-level checks for the Modbus RTU frame builder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mbrtu_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_has_value,
  input wire logic       in_end_of_frame,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_frame_byte,
  input wire logic       out_final_byte
);

  // A stalled output word holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_frame_byte)
      && $stable(out_final_byte))
    else $error("output word changed while stalled");

  // The output register is empty right after reset.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

  // With no word pending on either side and no new word taken, input is open.
  a_idle_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(in_valid && in_ready) && !out_valid |-> in_ready)
    else $error("input blocked while nothing is pending");

  // A word with a value or a frame end is followed by a valid output byte.
  a_word_emits: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_has_value || in_end_of_frame) |-> ##2 out_valid)
    else $error("accepted word produced no output");

endmodule : mbrtu_checker

bind modbus_rtu_frame_builder mbrtu_checker u_mbrtu_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .in_has_value    (in_has_value),
  .in_end_of_frame (in_end_of_frame),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_frame_byte  (out_frame_byte),
  .out_final_byte  (out_final_byte)
);

`default_nettype wire
